>>> hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lrhc_pkg.sv
`default_nettype none
package lrhc_pkg;
	localparam int BLOCK_HEADER_BYTES_DEF = 16;
	localparam int MIN_LEN = 24;
	localparam int MAX_LEN = 16 * 1024 * 1024;
	localparam int HEAD_MIN_BYTES = 12;
	localparam int AHEAD_LIMIT = 2048;
	localparam int FLAG_DEPEND = 2;
	localparam int FLAG_NEWMARK = 3;
	localparam int FLAG_OLDMARK = 4;
	localparam int DIV_STAGES = 17;
	localparam int FIFO_DEPTH = 4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_OFFSET = 3'd1;
	localparam logic [2:0] ST_NO_LENGTH = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_SEQ_RANGE = 3'd4;
	localparam logic [2:0] ST_BAD_FLAGS = 3'd5;

	localparam logic [1:0] FAIR_OK = 2'd0;
	localparam logic [1:0] FAIR_ABOVE = 2'd1;
	localparam logic [1:0] FAIR_BELOW = 2'd2;
	localparam logic [1:0] FAIR_AHEAD = 2'd3;

	localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
	localparam logic [2:0] REG_SCN_LOW = 3'd1;
	localparam logic [2:0] REG_SCN_NEXT = 3'd2;
	localparam logic [2:0] REG_WIN_EN = 3'd3;
	localparam logic [2:0] REG_WIN_LOW = 3'd4;
	localparam logic [2:0] REG_WIN_NEXT = 3'd5;

	// Classified item handed from the front part to the divider.
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  fair;
		logic [1:0]  kind;      // 0 ends here, 1 exact fit, 2 divide
		logic [15:0] near_off;  // offset + length when the record ends here
		logic [24:0] excess;
		logic [15:0] payload;
	} cls_t;

	localparam logic [1:0] KIND_HERE = 2'd0;
	localparam logic [1:0] KIND_FIT = 2'd1;
	localparam logic [1:0] KIND_DIV = 2'd2;

	// Result item.
	typedef struct packed {
		logic [2:0]  status;
		logic [20:0] span;
		logic [15:0] next_off;
		logic [1:0]  fair;
	} res_t;
endpackage
`default_nettype wire

>>> hdl/lrhc_front.sv
`default_nettype none
module lrhc_front import lrhc_pkg::*; #(
	parameter int BLOCK_HEADER_BYTES = BLOCK_HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] header_offset,
	input  wire logic [31:0] rec_length,
	input  wire logic [7:0]  flags,
	input  wire logic [15:0] scn_wrap,
	input  wire logic [31:0] scn_base,
	input  wire logic [15:0] block_size,
	input  wire logic [47:0] scn_low,
	input  wire logic [47:0] scn_next,
	input  wire logic        window_enable,
	input  wire logic [47:0] window_low,
	input  wire logic [47:0] window_next,
	output logic             cls_valid,
	input  wire logic        cls_ready,
	output cls_t             cls
);
	localparam logic [16:0] HDR = 17'(BLOCK_HEADER_BYTES);

	logic        v_s1_q;
	cls_t        cls_s1;
	logic [47:0] seq;
	logic        off_bad, len_bad, long_bad, seq_bad, flg_bad;
	logic [16:0] room;
	logic [48:0] d;
	logic        d_le0, d_le1, d_lt_lim;
	cls_t        c;

	assign in_ready = !v_s1_q || cls_ready;
	assign seq = {scn_wrap, scn_base};

	// Checks in the order given by the status priority.
	always_comb begin
		off_bad = ({1'b0, header_offset} < HDR)
			|| ({1'b0, header_offset} + 17'(HEAD_MIN_BYTES) > {1'b0, block_size});
		len_bad = (rec_length == '0) || (rec_length[1:0] != 2'b00)
			|| (rec_length < 32'(MIN_LEN));
		long_bad = rec_length > 32'(MAX_LEN);
		seq_bad = (seq < scn_low) || (seq > scn_next);
		flg_bad = (flags != 8'd0) && ((flags[4:0] == 5'd0)
			|| (flags[FLAG_NEWMARK] && flags[FLAG_OLDMARK]));
		room = {1'b0, block_size} - {1'b0, header_offset};
		d = {1'b0, seq} - {1'b0, window_next};
		d_le0 = d[48] || (d == '0);
		d_le1 = d_le0 || (d == 49'd1);
		d_lt_lim = d < 49'(AHEAD_LIMIT);
		c = '0;
		if (off_bad) c.status = ST_BAD_OFFSET;
		else if (len_bad) c.status = ST_NO_LENGTH;
		else if (long_bad) c.status = ST_TOO_LONG;
		else if (seq_bad) c.status = ST_SEQ_RANGE;
		else if (flg_bad) c.status = ST_BAD_FLAGS;
		else c.status = ST_OK;
		if (rec_length < {15'd0, room}) c.kind = KIND_HERE;
		else if (rec_length == {15'd0, room}) c.kind = KIND_FIT;
		else c.kind = KIND_DIV;
		c.near_off = header_offset + rec_length[15:0];
		c.excess = rec_length[24:0] - {8'd0, room};
		c.payload = block_size - HDR[15:0];
		if (!window_enable) c.fair = FAIR_OK;
		else if (seq < window_low) c.fair = FAIR_BELOW;
		else if (flags[FLAG_DEPEND]) c.fair = d_le1 ? FAIR_OK : FAIR_ABOVE;
		else if (d_le0) c.fair = FAIR_OK;
		else c.fair = d_lt_lim ? FAIR_ABOVE : FAIR_AHEAD;
		if (c.status != ST_OK) c.fair = FAIR_OK;
	end

	// Classification register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1_q <= 1'b0;
		else if (in_ready) v_s1_q <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) cls_s1 <= c;
	end

	assign cls_valid = v_s1_q;
	assign cls = cls_s1;
endmodule
`default_nettype wire

>>> hdl/lrhc_fifo.sv
`default_nettype none
module lrhc_fifo import lrhc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  cls_t      wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output cls_t      rd_data
);
	localparam int AW = $clog2(FIFO_DEPTH);

	cls_t          mem_q [FIFO_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(FIFO_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

>>> hdl/lrhc_back.sv
`default_nettype none
module lrhc_back import lrhc_pkg::*; #(
	parameter int BLOCK_HEADER_BYTES = BLOCK_HEADER_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cls_valid,
	output logic      cls_ready,
	input  cls_t      cls,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);
	// Restoring divider of a 25-bit excess by a 16-bit payload, at most 2 quotient
	// bits per stage; DIV_STAGES-1 division stages and one finishing stage.
	localparam int NB = 25;
	localparam int ND = DIV_STAGES - 1;
	localparam int BPS = (NB + ND - 1) / ND;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  fair;
		logic [1:0]  kind;
		logic [15:0] near_off;
		logic [15:0] payload;
		logic [16:0] rem;
		logic [24:0] num;  // shifts out numerator bits, shifts in quotient bits
	} dv_t;

	logic      adv;
	logic      v_q [DIV_STAGES+1];
	dv_t       st_q [ND+1];
	res_t      out_q;

	assign adv = !v_q[DIV_STAGES] || res_ready;
	assign cls_ready = adv;

	// Stage entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STAGES; i++) v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= cls_valid;
			for (int i = 1; i <= DIV_STAGES; i++) v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0].status <= cls.status;
			st_q[0].fair <= cls.fair;
			st_q[0].kind <= cls.kind;
			st_q[0].near_off <= cls.near_off;
			st_q[0].payload <= cls.payload;
			st_q[0].rem <= '0;
			st_q[0].num <= cls.excess;
		end
	end

	// Division stages.
	for (genvar g = 1; g <= ND; g++) begin : g_div
		dv_t nx;
		always_comb begin
			logic [17:0] t;
			t = '0;
			nx = st_q[g-1];
			for (int b = 0; b < BPS; b++) begin
				if ((g-1)*BPS + b < NB) begin
					t = {nx.rem, nx.num[NB-1]};
					nx.num = {nx.num[NB-2:0], 1'b0};
					if (t >= {2'b00, nx.payload}) begin
						t = t - {2'b00, nx.payload};
						nx.num[0] = 1'b1;
					end
					nx.rem = t[16:0];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) st_q[g] <= nx;
		end
	end

	// Result formation.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.status <= st_q[ND].status;
			out_q.fair <= st_q[ND].fair;
			out_q.span <= '0;
			out_q.next_off <= '0;
			if (st_q[ND].status == ST_OK) begin
				case (st_q[ND].kind)
					KIND_HERE: out_q.next_off <= st_q[ND].near_off;
					KIND_FIT: begin
						out_q.span <= 21'd1;
						out_q.next_off <= 16'(BLOCK_HEADER_BYTES);
					end
					default: begin
						out_q.span <= st_q[ND].num[20:0] + 21'd1;
						out_q.next_off <= 16'(BLOCK_HEADER_BYTES) + st_q[ND].rem[15:0];
					end
				endcase
			end
		end
	end

	assign res_valid = v_q[DIV_STAGES];
	assign res = out_q;
endmodule
`default_nettype wire

>>> hdl/log_record_header_checker.sv
`default_nettype none
// Log record header checker: checks one record header per item (offset, length,
// sequence window, flags), gives a status code, the further blocks spanned, the
// next header offset and a fairness grade. It accepts one item per cycle while the
// result side does not stall; an item passes the front classification register,
// the queue and the register stages of the pipelined divider that splits the
// excess length by the block payload size.
// A four-entry queue separates the two parts.
`include "assert_macros.svh"
module log_record_header_checker import lrhc_pkg::*; #(
	parameter int BLOCK_HEADER_BYTES = BLOCK_HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] header_offset,
	input  wire logic [31:0] rec_length,
	input  wire logic [7:0]  flags,
	input  wire logic [15:0] scn_wrap,
	input  wire logic [31:0] scn_base,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [20:0]      blocks_spanned,
	output logic [15:0]      following_offset,
	output logic [1:0]       fair_status
);
	logic [15:0] block_size_q;
	logic [47:0] scn_low_q, scn_next_q, win_low_q, win_next_q;
	logic        win_en_q;
	logic [2:0]  ridx;
	logic        f_valid, f_ready, q_valid, q_ready;
	cls_t        f_cls, q_cls;
	res_t        res;

	assign pready = 1'b1;
	assign ridx = paddr[5:3];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= 16'd512;
			scn_low_q <= '0;
			scn_next_q <= '1;
			win_en_q <= 1'b0;
			win_low_q <= '0;
			win_next_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_BLOCK_SIZE: block_size_q <= pwdata[15:0];
				REG_SCN_LOW: scn_low_q <= pwdata[47:0];
				REG_SCN_NEXT: scn_next_q <= pwdata[47:0];
				REG_WIN_EN: win_en_q <= pwdata[0];
				REG_WIN_LOW: win_low_q <= pwdata[47:0];
				REG_WIN_NEXT: win_next_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (ridx)
			REG_BLOCK_SIZE: prdata = {48'd0, block_size_q};
			REG_SCN_LOW: prdata = {16'd0, scn_low_q};
			REG_SCN_NEXT: prdata = {16'd0, scn_next_q};
			REG_WIN_EN: prdata = {63'd0, win_en_q};
			REG_WIN_LOW: prdata = {16'd0, win_low_q};
			REG_WIN_NEXT: prdata = {16'd0, win_next_q};
			default: prdata = '0;
		endcase
	end

	lrhc_front #(.BLOCK_HEADER_BYTES(BLOCK_HEADER_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.header_offset, .rec_length, .flags, .scn_wrap, .scn_base,
		.block_size(block_size_q), .scn_low(scn_low_q), .scn_next(scn_next_q),
		.window_enable(win_en_q), .window_low(win_low_q), .window_next(win_next_q),
		.cls_valid(f_valid), .cls_ready(f_ready), .cls(f_cls)
	);

	lrhc_fifo u_fifo (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cls),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cls)
	);

	lrhc_back #(.BLOCK_HEADER_BYTES(BLOCK_HEADER_BYTES)) u_back (
		.clk, .arst_n, .cls_valid(q_valid), .cls_ready(q_ready), .cls(q_cls),
		.res_valid(out_valid), .res_ready(out_ready), .res
	);

	assign status = res.status;
	assign blocks_spanned = res.span;
	assign following_offset = res.next_off;
	assign fair_status = res.fair;

	`CHK_IMPLY(a_rej_zero, clk, arst_n, out_valid && status != ST_OK,
		blocks_spanned == '0 && following_offset == '0 && fair_status == FAIR_OK,
		"rejected header carries nonzero fields")
	`CHK_IMPLY(a_status_range, clk, arst_n, out_valid,
		status <= ST_BAD_FLAGS, "status code out of range")
	`CHK_NEXT(a_win_off, clk, arst_n, !win_en_q && in_valid && in_ready,
		!f_valid || f_cls.fair == FAIR_OK, "fair grade set with window disabled")
endmodule
`default_nettype wire

>>> dv/header_result_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module header_result_checker import lrhc_pkg::*; #(
	parameter int HDR_BYTES = BLOCK_HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	input  wire logic        pready,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [15:0] header_offset,
	input  wire logic [31:0] rec_length,
	input  wire logic [7:0]  flags,
	input  wire logic [15:0] scn_wrap,
	input  wire logic [31:0] scn_base,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [2:0]  status,
	input  wire logic [20:0] blocks_spanned,
	input  wire logic [15:0] following_offset,
	input  wire logic [1:0]  fair_status,
	output int               fail_count,
	output int               pending
);
	// Mirror of the configuration registers.
	logic [15:0] cfg_block_size;
	logic [47:0] cfg_scn_low;
	logic [47:0] cfg_scn_next;
	logic        cfg_win_en;
	logic [47:0] cfg_win_low;
	logic [47:0] cfg_win_next;

	res_t expected_results[$];

	// Grade a record against the fairness window.
	function automatic logic [1:0] grade_fairness(logic [47:0] seq, logic [7:0] f);
		longint d;
		if (!cfg_win_en) return FAIR_OK;
		if (seq < cfg_win_low) return FAIR_BELOW;
		d = longint'({16'd0, seq}) - longint'({16'd0, cfg_win_next});
		if (f[FLAG_DEPEND]) return (d <= 1) ? FAIR_OK : FAIR_ABOVE;
		if (d <= 0) return FAIR_OK;
		return (d < AHEAD_LIMIT) ? FAIR_ABOVE : FAIR_AHEAD;
	endfunction

	// Work out the result that one header item must produce.
	function automatic res_t predict_header_result(logic [15:0] off, logic [31:0] len,
			logic [7:0] f, logic [47:0] seq);
		res_t r;
		longint room, payload, excess;
		r = '0;
		if (off < HDR_BYTES || longint'(off) + HEAD_MIN_BYTES > longint'(cfg_block_size))
			r.status = ST_BAD_OFFSET;
		else if (len == 0 || len[1:0] != 2'b00 || len < MIN_LEN)
			r.status = ST_NO_LENGTH;
		else if (len > MAX_LEN)
			r.status = ST_TOO_LONG;
		else if (seq < cfg_scn_low || seq > cfg_scn_next)
			r.status = ST_SEQ_RANGE;
		else if (f != 0 && (f[4:0] == 0 || (f[FLAG_NEWMARK] && f[FLAG_OLDMARK])))
			r.status = ST_BAD_FLAGS;
		else
			r.status = ST_OK;
		if (r.status == ST_OK) begin
			room = longint'(cfg_block_size) - longint'(off);
			payload = longint'(cfg_block_size) - HDR_BYTES;
			if (longint'(len) < room) begin
				r.span = '0;
				r.next_off = 16'(longint'(off) + longint'(len));
			end else if (longint'(len) == room) begin
				r.span = 21'd1;
				r.next_off = 16'(HDR_BYTES);
			end else begin
				excess = longint'(len) - room;
				r.span = 21'(excess / payload + 1);
				r.next_off = 16'(HDR_BYTES + excess % payload);
			end
			r.fair = grade_fairness(seq, f);
		end
		return r;
	endfunction

	// Track register writes, predict accepted items and compare results.
	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			cfg_block_size <= 16'd512;
			cfg_scn_low <= '0;
			cfg_scn_next <= '1;
			cfg_win_en <= 1'b0;
			cfg_win_low <= '0;
			cfg_win_next <= '0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_BLOCK_SIZE: cfg_block_size <= pwdata[15:0];
					REG_SCN_LOW: cfg_scn_low <= pwdata[47:0];
					REG_SCN_NEXT: cfg_scn_next <= pwdata[47:0];
					REG_WIN_EN: cfg_win_en <= pwdata[0];
					REG_WIN_LOW: cfg_win_low <= pwdata[47:0];
					REG_WIN_NEXT: cfg_win_next <= pwdata[47:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					predict_header_result(header_offset, rec_length,
					flags, {scn_wrap, scn_base}));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result item status=%0d span=%0d next=%0d fair=%0d",
						$time, status, blocks_spanned, following_offset, fair_status);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r != {status, blocks_spanned, following_offset, fair_status}) begin
						$display("%0t: mismatch status exp %0d got %0d, span exp %0d got %0d",
							$time, exp_r.status, status, exp_r.span, blocks_spanned);
						$display("%0t:   next offset exp %0d got %0d, fairness exp %0d got %0d",
							$time, exp_r.next_off, following_offset, exp_r.fair, fair_status);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_results.size();
		end
	end
endmodule
`default_nettype wire

>>> dv/log_record_header_checker_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module log_record_header_checker_tb;
	import lrhc_pkg::*;

	localparam int HDR = BLOCK_HEADER_BYTES_DEF;
	localparam int IDLE_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [15:0] header_offset;
	logic [31:0] rec_length;
	logic [7:0]  flags;
	logic [15:0] scn_wrap;
	logic [31:0] scn_base;
	logic        out_valid, out_ready;
	logic [2:0]  status;
	logic [20:0] blocks_spanned;
	logic [15:0] following_offset;
	logic [1:0]  fair_status;
	int          fail_count, pending;
	logic        stim_done;

	// Local copy of the settings, used only to shape the stimulus.
	int          bs;
	logic [47:0] seq_lo, seq_hi, win_lo, win_hi;
	bit          no_gaps;

	log_record_header_checker DUT (.*);
	header_result_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_gaps || r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_settings(int b, logic [47:0] lo, logic [47:0] hi, bit en,
			logic [47:0] wl, logic [47:0] wh);
		bs = b;
		seq_lo = lo;
		seq_hi = hi;
		win_lo = wl;
		win_hi = wh;
		write_reg(REG_BLOCK_SIZE, 64'(b));
		write_reg(REG_SCN_LOW, 64'(lo));
		write_reg(REG_SCN_NEXT, 64'(hi));
		write_reg(REG_WIN_EN, 64'(en));
		write_reg(REG_WIN_LOW, 64'(wl));
		write_reg(REG_WIN_NEXT, 64'(wh));
	endtask

	// Present one header item and hold it until accepted. Ready is looked at
	// mid-cycle, so the edge that follows a high ready is the accepting edge.
	task automatic send_header(logic [15:0] off, logic [31:0] len, logic [7:0] f,
			logic [47:0] seq);
		int gap;
		in_valid <= 1'b1;
		header_offset <= off;
		rec_length <= len;
		flags <= f;
		scn_wrap <= seq[47:32];
		scn_base <= seq[31:0];
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every result is back, then let the pipeline drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Mostly well-formed headers with random content, plus some noise.
	task automatic send_random_header();
		logic [15:0] off;
		logic [31:0] len;
		logic [7:0]  f;
		logic [47:0] seq;
		logic [63:0] span;
		int          r;
		r = $urandom_range(99);
		if (r < 10) begin
			send_header(16'($urandom), $urandom, 8'($urandom),
				{16'($urandom), 32'($urandom)});
		end else begin
			off = 16'($urandom_range(bs - 12, HDR));
			if ($urandom_range(19) == 0) off = 16'($urandom_range(HDR + 2, 0));
			case ($urandom_range(5))
				0: len = 32'(bs - off);
				1: len = $urandom_range(MAX_LEN / 4, 6) * 4;
				2: len = $urandom_range(bs * 8 / 4 + 6, 6) * 4;
				3: len = 32'($urandom_range(MAX_LEN / 4 + 2, MAX_LEN / 4 - 2) * 4);
				4: len = 32'($urandom_range(40));
				default: len = $urandom_range(64, 6) * 4;
			endcase
			case ($urandom_range(6))
				0: f = 8'h00;
				1: f = 8'h04;
				2: f = 8'h08;
				3: f = 8'h10;
				4: f = 8'h18 | 8'($urandom);
				default: f = 8'($urandom);
			endcase
			span = 64'(seq_hi) - 64'(seq_lo) + 1;
			seq = 48'(64'(seq_lo) + ({$urandom, $urandom} % span));
			if ($urandom_range(2) == 0) seq = win_hi + 48'($urandom_range(6000)) - 48'd3000;
			if ($urandom_range(9) == 0) seq = win_lo - 48'($urandom_range(2));
			if ($urandom_range(19) == 0) seq = seq_lo - 48'd1;
			if ($urandom_range(19) == 0) seq = seq_hi + 48'd1;
			send_header(off, len, f, seq);
		end
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(49) == 0) no_gaps = !no_gaps;
			send_random_header();
		end
	endtask

	// Result side stalls at random.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(20, 1)) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Watchdog on cycles with no handshake at all.
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel || stim_done)
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		header_offset = '0;
		rec_length = '0;
		flags = '0;
		scn_wrap = '0;
		scn_base = '0;
		stim_done = 1'b0;
		no_gaps = 1'b0;
		bs = 512;
		seq_lo = '0;
		seq_hi = '1;
		win_lo = '0;
		win_hi = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings.
		random_phase(250);
		wait_idle();

		// Directed headers around every check boundary.
		apply_settings(512, 48'd100, 48'h7FFF_FFFF_FFFF, 1'b1, 48'h1000, 48'h2000);
		send_header(16'd15, 32'd64, 8'h04, 48'h2000);
		send_header(16'd16, 32'd64, 8'h04, 48'h2000);
		send_header(16'd500, 32'd24, 8'h08, 48'h2000);
		send_header(16'd501, 32'd24, 8'h08, 48'h2000);
		send_header(16'hFFFF, 32'd24, 8'h08, 48'h2000);
		send_header(16'd16, 32'd0, 8'h04, 48'h2000);
		send_header(16'd16, 32'd22, 8'h04, 48'h2000);
		send_header(16'd16, 32'd20, 8'h04, 48'h2000);
		send_header(16'd16, 32'd24, 8'h00, 48'h2000);
		send_header(16'd16, MAX_LEN, 8'h01, 48'h2000);
		send_header(16'd16, MAX_LEN + 4, 8'h01, 48'h2000);
		send_header(16'd16, 32'hFFFF_FFFF, 8'h01, 48'h2000);
		send_header(16'd16, 32'd64, 8'h04, 48'd99);
		send_header(16'd16, 32'd64, 8'h04, 48'h8000_0000_0000);
		send_header(16'd16, 32'd64, 8'h20, 48'h2000);
		send_header(16'd16, 32'd64, 8'h18, 48'h2000);
		send_header(16'd16, 32'd64, 8'hFF, 48'h2000);
		send_header(16'd100, 32'd412, 8'h10, 48'h2000);
		send_header(16'd100, 32'd416, 8'h10, 48'h2000);
		send_header(16'd100, 32'd2000, 8'h10, 48'h2000);
		send_header(16'd16, 32'd64, 8'h04, 48'h0FFF);
		send_header(16'd16, 32'd64, 8'h04, 48'h2001);
		send_header(16'd16, 32'd64, 8'h04, 48'h2002);
		send_header(16'd16, 32'd64, 8'h08, 48'h27FF);
		send_header(16'd16, 32'd64, 8'h08, 48'h2800);
		random_phase(250);
		wait_idle();

		// Smallest block, window at the top of the sequence range.
		apply_settings(32, 48'd0, '1, 1'b1, 48'hFFFF_FFFF_F000, '1);
		random_phase(250);
		wait_idle();

		// Largest block, narrow sequence range, window at zero.
		apply_settings(65535, 48'h1234_0000_0000, 48'h1234_0000_FFFF, 1'b1, '0, '0);
		random_phase(250);
		wait_idle();

		// Middling block, window switched off.
		apply_settings(1000, 48'h10, 48'h4000, 1'b0, 48'h100, 48'h200);
		random_phase(250);
		wait_idle();

		// Odd block size, window above the range ends.
		apply_settings(4099, '0, 48'hFFFF_0000_0000, 1'b1, '1, 48'hFFFF_FFFF_FFF0);
		random_phase(250);
		wait_idle();

		stim_done = 1'b1;
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
